// ===== hw/rtl/bfp_pkg.sv =====
// Shared widths, reset values, register indexes, status codes and types for the FET protection block.
`default_nettype none

package bfp_pkg;

    localparam int ADC_W       = 10;
    localparam int SUM_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int OFFSET_W    = 12;
    localparam int THRESH_W    = 15;
    localparam int DEBOUNCE_W  = 16;
    localparam int HOLD_W      = 20;
    localparam int MV_W        = 16;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam int BFP_SAMPLES_PER_WINDOW = 10;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VOLT_GAIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLT_OFFSET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERVOLT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALID   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD        = 3'd6;

    // Register reset values
    localparam logic [GAIN_W-1:0]          RST_VOLT_GAIN   = 16'd26549;
    localparam logic signed [OFFSET_W-1:0] RST_VOLT_OFFSET = -12'sd82;
    localparam logic [THRESH_W-1:0]        RST_OVERVOLT    = 15'd15000;
    localparam logic [THRESH_W-1:0]        RST_CUTOFF      = 15'd13000;
    localparam logic [THRESH_W-1:0]        RST_MIN_VALID   = 15'd1000;
    localparam logic [DEBOUNCE_W-1:0]      RST_DEBOUNCE    = 16'd15000;
    localparam logic [HOLD_W-1:0]          RST_HOLD        = 20'd100000;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_CHARGING  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CUTOFF    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BATT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVP_COUNT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVP_TRIP  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HOLDING   = 3'd5;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] volt_offset_mv;
        logic [THRESH_W-1:0]        overvolt_mv;
        logic [THRESH_W-1:0]        cutoff_mv;
        logic [THRESH_W-1:0]        min_valid_mv;
        logic [DEBOUNCE_W-1:0]      debounce_limit;
        logic [HOLD_W-1:0]          hold_windows;
    } bfp_thresh_t;

    typedef struct packed {
        logic                   fet_on;
        logic                   led_on;
        logic signed [MV_W-1:0] battery_mv;
        logic [STATUS_W-1:0]    status;
    } bfp_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/battery_fet_protection.sv =====
// Battery charging-FET protection: window average, mV conversion, overvoltage debounce and hold.
// Throughput: one sample beat per cycle while in_stall is low; one result beat per SAMPLES_PER_WINDOW samples.
// Path: the window's last sample beat enters the window register; the reciprocal-multiply divide
// loads the average register, the gain multiply the scaled one, the decision the output reg.
// Reset (rst_n, async, active low): window, debounce, hold and the FET and LED latches clear;
// configuration registers take their calibrated defaults; no result pending.
`default_nettype none

module battery_fet_protection
#(
    parameter int SAMPLES_PER_WINDOW = bfp_pkg::BFP_SAMPLES_PER_WINDOW
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_wr_en,
    input  wire logic [bfp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [bfp_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [bfp_pkg::ADC_W-1:0]           adc_sample,
    input  wire logic                                blink_phase,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     fet_on,
    output logic                                     led_on,
    output logic signed [bfp_pkg::MV_W-1:0]          battery_mv,
    output logic [bfp_pkg::STATUS_W-1:0]             status
);
    import bfp_pkg::*;

    // Window sample counter only needs to reach the window length.
    localparam int CNT_W = $clog2(SAMPLES_PER_WINDOW + 1);

    // Truncating divide by the window length as a reciprocal multiply.
    // With sums below 2^16 and a rounding error below 2^6, a 23-bit shift is exact.
    localparam int DIV_SHIFT = 23;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES_PER_WINDOW) - 64'd1)
                 / 64'(SAMPLES_PER_WINDOW));
    localparam int QPROD_W = SUM_W + RECIP_W;
    localparam int GPROD_W = ADC_W + GAIN_W;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [GAIN_W-1:0] volt_gain_reg;
    bfp_thresh_t       thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_gain_reg               <= RST_VOLT_GAIN;
            thresh_reg.volt_offset_mv   <= RST_VOLT_OFFSET;
            thresh_reg.overvolt_mv      <= RST_OVERVOLT;
            thresh_reg.cutoff_mv        <= RST_CUTOFF;
            thresh_reg.min_valid_mv     <= RST_MIN_VALID;
            thresh_reg.debounce_limit   <= RST_DEBOUNCE;
            thresh_reg.hold_windows     <= RST_HOLD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_VOLT_GAIN:   volt_gain_reg             <= cfg_data[GAIN_W-1:0];
                REG_VOLT_OFFSET: thresh_reg.volt_offset_mv <= signed'(cfg_data[OFFSET_W-1:0]);
                REG_OVERVOLT:    thresh_reg.overvolt_mv    <= cfg_data[THRESH_W-1:0];
                REG_CUTOFF:      thresh_reg.cutoff_mv      <= cfg_data[THRESH_W-1:0];
                REG_MIN_VALID:   thresh_reg.min_valid_mv   <= cfg_data[THRESH_W-1:0];
                REG_DEBOUNCE:    thresh_reg.debounce_limit <= cfg_data[DEBOUNCE_W-1:0];
                REG_HOLD:        thresh_reg.hold_windows   <= cfg_data[HOLD_W-1:0];
                default:         ; // drop writes to unused indexes
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline flow control: each stage advances when the one after it
    // is empty or moving on, so a waiting result backs up and can stall sampling.
    // ---------------------------------------------------------------------
    logic win_valid_reg;
    logic avg_valid_reg;
    logic scl_valid_reg;
    logic out_valid_reg;

    logic out_ready;
    logic scl_ready;
    logic avg_ready;
    logic win_ready;
    logic in_fire;
    logic decide_fire;

    assign out_ready   = !out_valid_reg || !out_stall;
    assign scl_ready   = !scl_valid_reg || out_ready;
    assign avg_ready   = !avg_valid_reg || scl_ready;
    assign win_ready   = !win_valid_reg || avg_ready;
    assign in_stall    = !win_ready;
    assign in_fire     = in_valid && win_ready;
    assign decide_fire = scl_valid_reg && out_ready;

    // ---------------------------------------------------------------------
    // Stage 1: accumulate samples; hand the sum on when the window fills
    // ---------------------------------------------------------------------
    logic [SUM_W-1:0] window_sum_reg;
    logic [CNT_W-1:0] window_count_reg;
    logic [SUM_W-1:0] window_sum_next;
    logic [CNT_W:0]   window_count_next;
    logic             window_done;
    logic [SUM_W-1:0] win_sum_reg;
    logic             win_blink_reg;

    assign window_sum_next   = window_sum_reg + SUM_W'(adc_sample);
    assign window_count_next = {1'b0, window_count_reg} + (CNT_W+1)'(1);
    assign window_done       = window_count_next >= (CNT_W+1)'(SAMPLES_PER_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_sum_reg   <= '0;
            window_count_reg <= '0;
            win_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (window_done)
                begin
                    window_sum_reg   <= '0;
                    window_count_reg <= '0;
                end
                else
                begin
                    window_sum_reg   <= window_sum_next;
                    window_count_reg <= window_count_next[CNT_W-1:0];
                end
                win_valid_reg <= window_done;
            end
            else if (avg_ready)
            begin
                win_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && window_done)
        begin
            win_sum_reg   <= window_sum_next;
            win_blink_reg <= blink_phase;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: average = sum / window length via reciprocal multiply
    // ---------------------------------------------------------------------
    logic [QPROD_W-1:0] quot_prod;
    logic [ADC_W-1:0]   avg_reg;
    logic               avg_blink_reg;

    assign quot_prod = QPROD_W'(win_sum_reg) * QPROD_W'(DIV_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_valid_reg <= 1'b0;
        end
        else if (avg_ready)
        begin
            avg_valid_reg <= win_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (avg_ready && win_valid_reg)
        begin
            // Average never exceeds the largest sample, so ten bits hold it.
            avg_reg       <= quot_prod[DIV_SHIFT +: ADC_W];
            avg_blink_reg <= win_blink_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: scale by the Q.10 gain and clamp to the positive range
    // ---------------------------------------------------------------------
    logic [GPROD_W-1:0]  gain_prod;
    logic [THRESH_W-1:0] scaled_next;
    logic [THRESH_W-1:0] scl_mv_reg;
    logic                scl_blink_reg;

    assign gain_prod = GPROD_W'(avg_reg) * GPROD_W'(volt_gain_reg);

    always_comb
    begin
        if (gain_prod[GPROD_W-1])
        begin
            scaled_next = '1;
        end
        else
        begin
            scaled_next = gain_prod[10 +: THRESH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_valid_reg <= 1'b0;
        end
        else if (scl_ready)
        begin
            scl_valid_reg <= avg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scl_ready && avg_valid_reg)
        begin
            scl_mv_reg    <= scaled_next;
            scl_blink_reg <= avg_blink_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Decision: offset, clamp and protection rules; state moves on only
    // when the result beat is loaded into the output register.
    // ---------------------------------------------------------------------
    bfp_result_t decide_result;
    bfp_result_t out_result_reg;

    bfp_decide u_decide
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (decide_fire),
        .scaled_mv (scl_mv_reg),
        .blink     (scl_blink_reg),
        .thresh    (thresh_reg),
        .result    (decide_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (decide_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide_fire)
        begin
            out_result_reg <= decide_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fet_on     = out_result_reg.fet_on;
    assign led_on     = out_result_reg.led_on;
    assign battery_mv = out_result_reg.battery_mv;
    assign status     = out_result_reg.status;

endmodule

`default_nettype wire

// ===== hw/rtl/bfp_decide.sv =====
// Offset, clamp and protection decision with the debounce, hold and latch state.
`default_nettype none

module bfp_decide
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               fire,
    input  wire logic [bfp_pkg::THRESH_W-1:0]       scaled_mv,
    input  wire logic                               blink,
    input  wire bfp_pkg::bfp_thresh_t               thresh,
    output bfp_pkg::bfp_result_t                    result
);
    import bfp_pkg::*;

    localparam int WIDE_W = THRESH_W + 2;

    logic [DEBOUNCE_W-1:0] overvolt_count_reg;
    logic [DEBOUNCE_W-1:0] overvolt_count_next;
    logic [HOLD_W-1:0]     hold_left_reg;
    logic [HOLD_W-1:0]     hold_left_next;
    logic                  fet_latch_reg;
    logic                  fet_latch_next;
    logic                  led_latch_reg;
    logic                  led_latch_next;

    logic signed [WIDE_W-1:0] mv_sum;
    logic signed [WIDE_W-1:0] mv_clamped;
    logic [DEBOUNCE_W:0]      count_inc;
    logic [STATUS_W-1:0]      status_next;

    always_comb
    begin
        // Scaled value is never negative, so only the top bound can bite.
        mv_sum = signed'({2'b00, scaled_mv}) + WIDE_W'(thresh.volt_offset_mv);
        if (mv_sum > signed'(WIDE_W'(32767)))
        begin
            mv_clamped = signed'(WIDE_W'(32767));
        end
        else
        begin
            mv_clamped = mv_sum;
        end

        count_inc           = {1'b0, overvolt_count_reg} + (DEBOUNCE_W+1)'(1);
        overvolt_count_next = overvolt_count_reg;
        hold_left_next      = hold_left_reg;
        fet_latch_next      = fet_latch_reg;
        led_latch_next      = led_latch_reg;
        status_next         = ST_CHARGING;

        if (mv_clamped >= signed'({2'b00, thresh.overvolt_mv}))
        begin
            if (count_inc >= {1'b0, thresh.debounce_limit})
            begin
                overvolt_count_next = thresh.debounce_limit;
                hold_left_next      = thresh.hold_windows;
                fet_latch_next      = 1'b0;
                led_latch_next      = blink;
                status_next         = ST_OVP_TRIP;
            end
            else
            begin
                overvolt_count_next = count_inc[DEBOUNCE_W-1:0];
                status_next         = ST_OVP_COUNT;
            end
        end
        else
        begin
            overvolt_count_next = '0;
            if (hold_left_reg != '0)
            begin
                hold_left_next = hold_left_reg - HOLD_W'(1);
                led_latch_next = blink;
                status_next    = ST_HOLDING;
            end
            else if (mv_clamped <= signed'({2'b00, thresh.min_valid_mv}))
            begin
                fet_latch_next = 1'b0;
                led_latch_next = 1'b0;
                status_next    = ST_NO_BATT;
            end
            else if (mv_clamped >= signed'({2'b00, thresh.cutoff_mv}))
            begin
                fet_latch_next = 1'b0;
                led_latch_next = 1'b0;
                status_next    = ST_CUTOFF;
            end
            else
            begin
                fet_latch_next = 1'b1;
                led_latch_next = 1'b1;
                status_next    = ST_CHARGING;
            end
        end

        result.fet_on     = fet_latch_next;
        result.led_on     = led_latch_next;
        result.battery_mv = mv_clamped[MV_W-1:0];
        result.status     = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overvolt_count_reg <= '0;
            hold_left_reg      <= '0;
            fet_latch_reg      <= 1'b0;
            led_latch_reg      <= 1'b0;
        end
        else if (fire)
        begin
            overvolt_count_reg <= overvolt_count_next;
            hold_left_reg      <= hold_left_next;
            fet_latch_reg      <= fet_latch_next;
            led_latch_reg      <= led_latch_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_battery_fet_protection.sv =====
// Self-checking testbench for battery_fet_protection: directed windows, then randomised phases.

module tb_battery_fet_protection;
    timeunit 1ns;
    timeprecision 1ps;

    import bfp_pkg::*;

    localparam int WINDOW            = BFP_SAMPLES_PER_WINDOW;
    // Result leaves the block through the window, average, scaled and output registers; allow margin.
    localparam int SETTLE_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int RANDOM_PHASES     = 8;
    localparam int WINDOWS_PER_PHASE = 11;
    localparam int ADC_MAX           = (1 << ADC_W) - 1;
    localparam int MV_FLOOR          = -2048;
    localparam int MV_CEIL           = 32767;
    // Slowest correct run: about 1300 beats, each behind the longest gap and the longest
    // stall, plus the long hold-offs and config drains, stays below this limit.
    localparam int CYCLE_LIMIT       = 1000000;

    // Index 7 decodes to no register; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    // Calibration and threshold settings as the block holds them.
    typedef struct packed {
        logic [GAIN_W-1:0]          gain;
        logic signed [OFFSET_W-1:0] offset;
        logic [THRESH_W-1:0]        overvolt;
        logic [THRESH_W-1:0]        cutoff;
        logic [THRESH_W-1:0]        min_valid;
        logic [DEBOUNCE_W-1:0]      debounce;
        logic [HOLD_W-1:0]          hold;
    } fet_cfg_t;

    // Settings loaded before a directed window; PS_KEEP leaves the registers alone.
    typedef enum int {PS_KEEP, PS_HIGH, PS_LOW, PS_SMALL} preset_t;

    // One directed window: ten equal samples and, where obvious, the result it gives.
    typedef struct {
        preset_t                preset;
        logic [ADC_W-1:0]       adc;
        logic                   blink;
        bit                     typed;
        logic                   fet;
        logic                   led;
        logic signed [MV_W-1:0] mv;
        logic [STATUS_W-1:0]    st;
    } dir_row_t;

    // Rows with typed = 0 are checked against the predictor alone.
    dir_row_t dir_table [25] = '{
        // reset calibration: empty reading, then overvoltage count, charge and cutoff
        '{PS_KEEP,  10'd0,    1'b0, 1'b1, 1'b0, 1'b0, -16'sd82,   ST_NO_BATT},
        '{PS_KEEP,  10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, 16'sd0,     ST_CHARGING},
        '{PS_KEEP,  10'd500,  1'b0, 1'b0, 1'b0, 1'b0, 16'sd0,     ST_CHARGING},
        '{PS_KEEP,  10'd540,  1'b1, 1'b0, 1'b0, 1'b0, 16'sd0,     ST_CHARGING},
        // top of the gain, offset, overvoltage and cutoff ranges: clamp high, zero debounce trips at once, zero hold
        '{PS_HIGH,  10'd1023, 1'b1, 1'b1, 1'b0, 1'b1, 16'sd32767, ST_OVP_TRIP},
        '{PS_KEEP,  10'd0,    1'b0, 1'b1, 1'b1, 1'b1, 16'sd2047,  ST_CHARGING},
        '{PS_KEEP,  10'd1023, 1'b0, 1'b1, 1'b0, 1'b0, 16'sd32767, ST_OVP_TRIP},
        '{PS_KEEP,  10'd0,    1'b1, 1'b1, 1'b1, 1'b1, 16'sd2047,  ST_CHARGING},
        // bottom of the gain, offset, overvoltage and cutoff ranges, top of the others: zero gain, clamp low
        '{PS_LOW,   10'd1023, 1'b1, 1'b1, 1'b0, 1'b0, -16'sd2048, ST_NO_BATT},
        '{PS_KEEP,  10'd0,    1'b0, 1'b1, 1'b0, 1'b0, -16'sd2048, ST_NO_BATT},
        // unity gain: debounce of two, hold of two, every boundary
        '{PS_SMALL, 10'd1023, 1'b1, 1'b1, 1'b0, 1'b0, 16'sd1023,  ST_OVP_COUNT},
        '{PS_KEEP,  10'd1023, 1'b1, 1'b1, 1'b0, 1'b1, 16'sd1023,  ST_OVP_TRIP},
        '{PS_KEEP,  10'd1023, 1'b0, 1'b1, 1'b0, 1'b0, 16'sd1023,  ST_OVP_TRIP},
        '{PS_KEEP,  10'd500,  1'b1, 1'b1, 1'b0, 1'b1, 16'sd500,   ST_HOLDING},
        '{PS_KEEP,  10'd500,  1'b0, 1'b1, 1'b0, 1'b0, 16'sd500,   ST_HOLDING},
        '{PS_KEEP,  10'd500,  1'b1, 1'b1, 1'b1, 1'b1, 16'sd500,   ST_CHARGING},
        '{PS_KEEP,  10'd900,  1'b0, 1'b1, 1'b1, 1'b1, 16'sd900,   ST_OVP_COUNT},
        '{PS_KEEP,  10'd899,  1'b1, 1'b1, 1'b0, 1'b0, 16'sd899,   ST_CUTOFF},
        '{PS_KEEP,  10'd700,  1'b0, 1'b1, 1'b0, 1'b0, 16'sd700,   ST_CUTOFF},
        '{PS_KEEP,  10'd699,  1'b1, 1'b1, 1'b1, 1'b1, 16'sd699,   ST_CHARGING},
        '{PS_KEEP,  10'd100,  1'b0, 1'b1, 1'b0, 1'b0, 16'sd100,   ST_NO_BATT},
        '{PS_KEEP,  10'd101,  1'b1, 1'b1, 1'b1, 1'b1, 16'sd101,   ST_CHARGING},
        '{PS_KEEP,  10'd900,  1'b0, 1'b1, 1'b1, 1'b1, 16'sd900,   ST_OVP_COUNT},
        '{PS_KEEP,  10'd899,  1'b1, 1'b1, 1'b0, 1'b0, 16'sd899,   ST_CUTOFF},
        '{PS_KEEP,  10'd900,  1'b0, 1'b1, 1'b0, 1'b0, 16'sd900,   ST_OVP_COUNT}
    };

    logic                        clk;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index   = '0;
    logic [CFG_DATA_W-1:0]       cfg_data    = '0;
    logic                        in_valid    = 1'b0;
    logic                        in_stall;
    logic [ADC_W-1:0]            adc_sample  = '0;
    logic                        blink_phase = 1'b0;
    logic                        out_valid;
    logic                        out_stall   = 1'b0;
    logic                        fet_on;
    logic                        led_on;
    logic signed [MV_W-1:0]      battery_mv;
    logic [STATUS_W-1:0]         status;

    // Predictor state: its own copy of the settings and of the window and latch state.
    fet_cfg_t                    cal;
    logic [SUM_W-1:0]            acc_sum;
    int                          acc_count;
    int unsigned                 ovp_run;
    logic [HOLD_W-1:0]           hold_left_m;
    logic                        fet_m;
    logic                        led_m;

    bfp_result_t                 pending_results [$];
    int                          mismatches    = 0;
    int                          cycle_count   = 0;
    bit                          idle_on       = 1'b0;
    bit                          long_hold_req = 1'b0;

    battery_fet_protection dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .adc_sample  (adc_sample),
        .blink_phase (blink_phase),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fet_on      (fet_on),
        .led_on      (led_on),
        .battery_mv  (battery_mv),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Return the predictor to the state the block takes at reset.
    function automatic void reset_model();
        cal.gain      = RST_VOLT_GAIN;
        cal.offset    = RST_VOLT_OFFSET;
        cal.overvolt  = RST_OVERVOLT;
        cal.cutoff    = RST_CUTOFF;
        cal.min_valid = RST_MIN_VALID;
        cal.debounce  = RST_DEBOUNCE;
        cal.hold      = RST_HOLD;
        acc_sum       = '0;
        acc_count     = 0;
        ovp_run       = 0;
        hold_left_m   = '0;
        fet_m         = 1'b0;
        led_m         = 1'b0;
    endfunction

    // Mirror one register write; bits above the register width are dropped.
    function automatic void model_write(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_VOLT_GAIN:   cal.gain      = data[GAIN_W-1:0];
            REG_VOLT_OFFSET: cal.offset    = data[OFFSET_W-1:0];
            REG_OVERVOLT:    cal.overvolt  = data[THRESH_W-1:0];
            REG_CUTOFF:      cal.cutoff    = data[THRESH_W-1:0];
            REG_MIN_VALID:   cal.min_valid = data[THRESH_W-1:0];
            REG_DEBOUNCE:    cal.debounce  = data[DEBOUNCE_W-1:0];
            REG_HOLD:        cal.hold      = data[HOLD_W-1:0];
            default:         ;
        endcase
    endfunction

    // Window average to clamped millivolts: Q.10 scale, clamp, add offset, clamp again.
    function automatic int average_to_mv(input int unsigned avg);
        int unsigned scaled;
        int          mv;
        scaled = (avg * int'(cal.gain)) >> 10;
        if (scaled > MV_CEIL)
            scaled = MV_CEIL;
        mv = int'(scaled) + int'($signed(cal.offset));
        if (mv > MV_CEIL)
            mv = MV_CEIL;
        if (mv < MV_FLOOR)
            mv = MV_FLOOR;
        return mv;
    endfunction

    // Advance the predictor by one sample beat; returns 1 when a window completes.
    function automatic bit predict_sample(input logic [ADC_W-1:0] s, input logic b,
                                          output bfp_result_t r);
        int unsigned avg;
        int unsigned nxt;
        int          mv;
        r = '0;
        acc_sum = acc_sum + s;
        acc_count++;
        if (acc_count < WINDOW)
            return 1'b0;
        avg = acc_sum / WINDOW;
        acc_sum = '0;
        acc_count = 0;
        mv = average_to_mv(avg);
        if (mv >= int'(cal.overvolt))
        begin
            nxt = ovp_run + 1;
            if (nxt >= int'(cal.debounce))
            begin
                // trip: count saturates, hold reloads, FET off, LED follows blink
                ovp_run     = cal.debounce;
                hold_left_m = cal.hold;
                fet_m       = 1'b0;
                led_m       = b;
                r.status    = ST_OVP_TRIP;
            end
            else
            begin
                ovp_run  = nxt;
                r.status = ST_OVP_COUNT;
            end
        end
        else
        begin
            ovp_run = 0;
            if (hold_left_m != '0)
            begin
                hold_left_m = hold_left_m - 1'b1;
                led_m       = b;
                r.status    = ST_HOLDING;
            end
            else if (mv <= int'(cal.min_valid))
            begin
                fet_m    = 1'b0;
                led_m    = 1'b0;
                r.status = ST_NO_BATT;
            end
            else if (mv >= int'(cal.cutoff))
            begin
                fet_m    = 1'b0;
                led_m    = 1'b0;
                r.status = ST_CUTOFF;
            end
            else
            begin
                fet_m    = 1'b1;
                led_m    = 1'b1;
                r.status = ST_CHARGING;
            end
        end
        r.fet_on     = fet_m;
        r.led_on     = led_m;
        r.battery_mv = MV_W'(mv);
        return 1'b1;
    endfunction

    // Idle length for either side: mostly none, a few short, the odd long one.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Zero, the maximum, or anything in between.
    function automatic int unsigned pick_edge(input int unsigned maxv);
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return 0;
        if (r == 1)
            return maxv;
        return $urandom_range(0, maxv);
    endfunction

    function automatic fet_cfg_t preset_setting(input preset_t p);
        fet_cfg_t s;
        case (p)
            PS_HIGH:  s = '{16'hFFFF, 12'h7FF, 15'd32767, 15'd32767, 15'd0,
                            16'd0, 20'd0};
            PS_LOW:   s = '{16'd0, 12'h800, 15'd0, 15'd0, 15'd32767,
                            16'hFFFF, 20'hFFFFF};
            PS_SMALL: s = '{16'd1024, 12'd0, 15'd900, 15'd700, 15'd100,
                            16'd2, 20'd2};
            default:  s = '{RST_VOLT_GAIN, RST_VOLT_OFFSET, RST_OVERVOLT, RST_CUTOFF,
                            RST_MIN_VALID, RST_DEBOUNCE, RST_HOLD};
        endcase
        return s;
    endfunction

    // Ordered thresholds in reach of the ADC range, short debounce and hold.
    function automatic fet_cfg_t tuned_setting();
        fet_cfg_t s;
        int       lo;
        int       mid;
        int       hi;
        lo = $urandom_range(200, 3000);
        mid = lo + int'($urandom_range(500, 8000));
        hi = mid + int'($urandom_range(0, 6000));
        s.gain      = GAIN_W'($urandom_range(16000, 40000));
        s.offset    = OFFSET_W'(int'($urandom_range(0, 400)) - 200);
        s.min_valid = THRESH_W'(lo);
        s.cutoff    = THRESH_W'(mid);
        s.overvolt  = THRESH_W'(hi);
        s.debounce  = ($urandom_range(0, 9) == 0) ? '0 : DEBOUNCE_W'($urandom_range(1, 4));
        s.hold      = HOLD_W'($urandom_range(0, 6));
        return s;
    endfunction

    function automatic fet_cfg_t extreme_setting();
        fet_cfg_t s;
        int       r;
        r = $urandom_range(0, 2);
        s.gain      = GAIN_W'(pick_edge(16'hFFFF));
        s.offset    = (r == 0) ? 12'h800 : (r == 1) ? 12'h7FF : OFFSET_W'($urandom);
        s.overvolt  = THRESH_W'(pick_edge(32767));
        s.cutoff    = THRESH_W'(pick_edge(32767));
        s.min_valid = THRESH_W'(pick_edge(32767));
        s.debounce  = DEBOUNCE_W'(pick_edge(16'hFFFF));
        s.hold      = HOLD_W'(pick_edge(20'hFFFFF));
        return s;
    endfunction

    // ADC level whose scaled value lands near the wanted millivolts.
    function automatic int mv_to_level(input fet_cfg_t s, input int target);
        int a;
        if (s.gain == '0)
            return $urandom_range(0, ADC_MAX);
        a = ((target - int'($signed(s.offset))) * 1024) / int'(s.gain);
        if (a < 0)
            a = 0;
        if (a > ADC_MAX)
            a = ADC_MAX;
        return a;
    endfunction

    // One register write beat; the predictor takes it at the same edge.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        model_write(idx, data);
    endtask

    // Write every register, with junk above each field, then poke the unused index.
    task automatic apply_setting(input fet_cfg_t s);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[GAIN_W-1:0] = s.gain;
        write_reg(REG_VOLT_GAIN, d);
        d = CFG_DATA_W'($urandom);
        d[OFFSET_W-1:0] = s.offset;
        write_reg(REG_VOLT_OFFSET, d);
        d = CFG_DATA_W'($urandom);
        d[THRESH_W-1:0] = s.overvolt;
        write_reg(REG_OVERVOLT, d);
        d = CFG_DATA_W'($urandom);
        d[THRESH_W-1:0] = s.cutoff;
        write_reg(REG_CUTOFF, d);
        d = CFG_DATA_W'($urandom);
        d[THRESH_W-1:0] = s.min_valid;
        write_reg(REG_MIN_VALID, d);
        d = CFG_DATA_W'($urandom);
        d[DEBOUNCE_W-1:0] = s.debounce;
        write_reg(REG_DEBOUNCE, d);
        d = CFG_DATA_W'($urandom);
        d[HOLD_W-1:0] = s.hold;
        write_reg(REG_HOLD, d);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Drop valid and hold until every expected result is back and the pipe is empty.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one sample beat, after an optional gap, and hold it until accepted.
    task automatic send_sample(input logic [ADC_W-1:0] s, input logic b,
                               input bit typed, input bfp_result_t typed_res);
        int          gap;
        bfp_result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        adc_sample  <= s;
        blink_phase <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_sample(s, b, r))
            pending_results.push_back(typed ? typed_res : r);
    endtask

    // A window of samples spread around a level; a negative level means raw noise.
    task automatic send_window(input int level, input int spread);
        int v;
        repeat (WINDOW)
        begin
            if (level < 0)
                v = $urandom_range(0, ADC_MAX);
            else
                v = level + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0)
                v = 0;
            if (v > ADC_MAX)
                v = ADC_MAX;
            send_sample(ADC_W'(v), 1'($urandom), 1'b0, '0);
        end
    endtask

    // Sender: reset, directed windows, then randomised phases, then the verdict.
    initial
    begin : stimulus
        int          i;
        int          p;
        int          w;
        int          r;
        int          t;
        int          burst;
        fet_cfg_t    s;
        bfp_result_t tres;
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        // Directed part: reload the settings where a row asks, then send its window.
        for (i = 0; i < $size(dir_table); i++)
        begin
            if (dir_table[i].preset != PS_KEEP)
            begin
                wait_for_results();
                apply_setting(preset_setting(dir_table[i].preset));
            end
            tres.fet_on     = dir_table[i].fet;
            tres.led_on     = dir_table[i].led;
            tres.battery_mv = dir_table[i].mv;
            tres.status     = dir_table[i].st;
            repeat (WINDOW)
                send_sample(dir_table[i].adc, dir_table[i].blink, dir_table[i].typed, tres);
        end

        // Random part: each phase drains, loads new settings, then streams windows.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_for_results();
            // phases 0 and 4 run flat out on both sides
            idle_on = (p != 0) && (p != 4);
            s = (p == 2 || p == 5) ? extreme_setting() : tuned_setting();
            apply_setting(s);
            // hold the receiver off for a long stretch so the block backs up to its input
            if (p == 1)
                long_hold_req = 1'b1;
            w = 0;
            while (w < WINDOWS_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                begin
                    // run of overvoltage windows to reach the debounce limit
                    burst = $urandom_range(1, 5);
                    repeat (burst)
                        send_window(mv_to_level(s, int'(s.overvolt)
                                                   + int'($urandom_range(0, 400))), 2);
                    w += burst;
                end
                else
                begin
                    if (r < 45)
                        t = int'(s.overvolt) + int'($urandom_range(0, 40)) - 20;
                    else if (r < 60)
                        t = int'(s.cutoff) + int'($urandom_range(0, 40)) - 20;
                    else if (r < 72)
                        t = int'(s.min_valid) + int'($urandom_range(0, 40)) - 20;
                    else
                        t = $urandom_range(0, MV_CEIL);
                    if (r < 87)
                        send_window(mv_to_level(s, t), (r < 72) ? 1 : 3);
                    else
                        send_window(-1, 0);
                    w++;
                end
            end
            // leave a partial window straddling the next settings change
            repeat ($urandom_range(0, WINDOW - 1))
                send_sample(ADC_W'($urandom), 1'($urandom), 1'b0, '0);
        end

        wait_for_results();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver stall: random bursts, or one long hold-off counted here when asked.
    initial
    begin : receiver_stall
        int hold_len;
        int free_len;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                hold_len = pick_gap();
                free_len = pick_gap() + 1;
                if (hold_len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold_len) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat (free_len) @(posedge clk);
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation, field by field.
    always @(posedge clk)
    begin : check_results
        bfp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: mv %0d status %0d",
                       battery_mv, status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (fet_on !== want.fet_on)
                begin
                    $error("fet_on: expected %0b, got %0b", want.fet_on, fet_on);
                    mismatches++;
                end
                if (led_on !== want.led_on)
                begin
                    $error("led_on: expected %0b, got %0b", want.led_on, led_on);
                    mismatches++;
                end
                if (battery_mv !== want.battery_mv)
                begin
                    $error("battery_mv: expected %0d, got %0d",
                           $signed(want.battery_mv), battery_mv);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if it goes far beyond the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
